FILE: rtl/u8n1_pkg.sv
// Shared types, constants and helper functions for the 8N1 UART transceiver.
// No dependencies; imported by every module of the block.
package u8n1_pkg;

  // Frame shape and register indexes.
  localparam int DATA_BITS = 8;
  localparam int BIT_IDX_W = $clog2(DATA_BITS);
  localparam int BIT_CNT_W = 4;

  localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_BREAK      = 2'd2;

  localparam logic [15:0] BIT_PERIOD_RST = 16'd416;
  localparam logic [15:0] TIMEOUT_RST    = 16'd65535;
  localparam logic [23:0] BREAK_RST      = 24'd5000;
  localparam logic [15:0] MIN_BIT_PERIOD = 16'd2;

  // Configuration as seen by the receiver and transmitter.
  typedef struct packed {
    logic [15:0] bit_period;
    logic [15:0] timeout_ticks;
    logic [23:0] break_ticks;
  } cfg_t;

  // Per-tick outputs of the receiver.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       timeout;
    logic       busy;
  } rx_result_t;

  // Per-tick outputs of the transmitter.
  typedef struct packed {
    logic line;
    logic busy;
  } tx_result_t;

  // One complete result item.
  typedef struct packed {
    tx_result_t tx;
    rx_result_t rx;
  } result_t;

  // Bit length with the lower bound applied.
  function automatic logic [15:0] full_bit(input cfg_t cfg);
    full_bit = (cfg.bit_period < MIN_BIT_PERIOD) ? MIN_BIT_PERIOD : cfg.bit_period;
  endfunction

  // Start/stop wait length, never zero.
  function automatic logic [15:0] wait_limit(input cfg_t cfg);
    wait_limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
  endfunction

  // Break length, never zero.
  function automatic logic [23:0] break_len(input cfg_t cfg);
    break_len = (cfg.break_ticks == 24'd0) ? 24'd1 : cfg.break_ticks;
  endfunction

endpackage

FILE: rtl/u8n1_rx.sv
// Receiver of the 8N1 UART: start wait, half-bit delay, data sampling, stop wait.
// Depends on u8n1_pkg for the configuration and result types.
module u8n1_rx (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  u8n1_pkg::cfg_t      cfg,
  input  logic                rx_line,
  input  logic                rx_arm,
  output u8n1_pkg::rx_result_t res
);
  import u8n1_pkg::*;

  localparam logic [2:0] RX_IDLE       = 3'd0;
  localparam logic [2:0] RX_WAIT_START = 3'd1;
  localparam logic [2:0] RX_HALF       = 3'd2;
  localparam logic [2:0] RX_BITS       = 3'd3;
  localparam logic [2:0] RX_WAIT_STOP  = 3'd4;

  logic [2:0]           phase, phase_next;
  logic [15:0]          timer, timer_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [BIT_CNT_W-1:0] bits, bits_next;

  // Working copy after arming, and the decremented timer.
  logic [2:0]           ph;
  logic [15:0]          tm;
  logic [DATA_BITS-1:0] sh;
  logic [BIT_CNT_W-1:0] bc;
  logic [15:0]          tm_dec;

  // Next state and this tick's outputs.
  always_comb begin
    ph = phase;
    tm = timer;
    sh = shift;
    bc = bits;
    if (phase == RX_IDLE && rx_arm) begin
      ph = RX_WAIT_START;
      tm = wait_limit(cfg);
      sh = '0;
      bc = '0;
    end
    tm_dec = tm - 16'd1;

    phase_next = ph;
    timer_next = tm;
    shift_next = sh;
    bits_next  = bc;
    res        = '0;
    res.busy   = (ph != RX_IDLE);

    case (ph)
      RX_IDLE: begin
      end
      RX_WAIT_START: begin
        if (!rx_line) begin
          phase_next = RX_HALF;
          timer_next = full_bit(cfg) >> 1;
        end else begin
          timer_next = tm_dec;
          if (tm_dec == 16'd0) begin
            res.timeout = 1'b1;
            phase_next  = RX_IDLE;
          end
        end
      end
      RX_HALF: begin
        timer_next = tm_dec;
        if (tm_dec == 16'd0) begin
          phase_next = RX_BITS;
          timer_next = full_bit(cfg);
        end
      end
      RX_BITS: begin
        timer_next = tm_dec;
        if (tm_dec == 16'd0) begin
          shift_next[bc[BIT_IDX_W-1:0]] = sh[bc[BIT_IDX_W-1:0]] | rx_line;
          bits_next = bc + BIT_CNT_W'(1);
          if (bits_next >= BIT_CNT_W'(DATA_BITS)) begin
            phase_next = RX_WAIT_STOP;
            timer_next = wait_limit(cfg);
          end else begin
            timer_next = full_bit(cfg);
          end
        end
      end
      RX_WAIT_STOP: begin
        if (rx_line) begin
          res.valid  = 1'b1;
          res.data   = sh[7:0];
          phase_next = RX_IDLE;
        end else begin
          timer_next = tm_dec;
          if (tm_dec == 16'd0) begin
            res.timeout = 1'b1;
            phase_next  = RX_IDLE;
          end
        end
      end
      default: begin
        phase_next = RX_IDLE;
      end
    endcase
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= RX_IDLE;
      timer <= '0;
      shift <= '0;
      bits  <= '0;
    end else if (step) begin
      phase <= phase_next;
      timer <= timer_next;
      shift <= shift_next;
      bits  <= bits_next;
    end
  end

endmodule

FILE: rtl/u8n1_tx.sv
// Transmitter of the 8N1 UART: start bit, data bits LSB first, stop bit, or a break.
// Depends on u8n1_pkg for the configuration and result types.
module u8n1_tx (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  u8n1_pkg::cfg_t      cfg,
  input  logic                tx_start,
  input  logic [7:0]          tx_data,
  input  logic                break_start,
  output u8n1_pkg::tx_result_t res
);
  import u8n1_pkg::*;

  localparam logic [2:0] TX_IDLE     = 3'd0;
  localparam logic [2:0] TX_STARTBIT = 3'd1;
  localparam logic [2:0] TX_DATA     = 3'd2;
  localparam logic [2:0] TX_STOPBIT  = 3'd3;
  localparam logic [2:0] TX_BREAK    = 3'd4;

  logic [2:0]           phase, phase_next;
  logic [23:0]          timer, timer_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [BIT_CNT_W-1:0] bits, bits_next;

  logic [2:0]           ph;
  logic [23:0]          tm;
  logic [DATA_BITS-1:0] sh;
  logic [BIT_CNT_W-1:0] bc;
  logic [23:0]          tm_dec;
  logic [23:0]          full24;

  // Next state and this tick's line level.
  always_comb begin
    full24 = {8'd0, full_bit(cfg)};
    ph = phase;
    tm = timer;
    sh = shift;
    bc = bits;
    if (phase == TX_IDLE) begin
      if (tx_start) begin
        ph = TX_STARTBIT;
        tm = full24;
        sh = DATA_BITS'(tx_data);
        bc = '0;
      end else if (break_start) begin
        ph = TX_BREAK;
        tm = break_len(cfg);
      end
    end
    tm_dec = tm - 24'd1;

    phase_next = ph;
    timer_next = tm;
    shift_next = sh;
    bits_next  = bc;
    res.busy   = (ph != TX_IDLE);
    res.line   = 1'b1;

    case (ph)
      TX_IDLE: begin
      end
      TX_STARTBIT: begin
        res.line   = 1'b0;
        timer_next = tm_dec;
        if (tm_dec == 24'd0) begin
          phase_next = TX_DATA;
          timer_next = full24;
        end
      end
      TX_DATA: begin
        res.line   = sh[0];
        timer_next = tm_dec;
        if (tm_dec == 24'd0) begin
          shift_next = sh >> 1;
          bits_next  = bc + BIT_CNT_W'(1);
          if (bits_next >= BIT_CNT_W'(DATA_BITS)) begin
            phase_next = TX_STOPBIT;
          end
          timer_next = full24;
        end
      end
      TX_BREAK: begin
        res.line   = 1'b0;
        timer_next = tm_dec;
        if (tm_dec == 24'd0) begin
          phase_next = TX_IDLE;
        end
      end
      default: begin
        // Stop bit: line high until the bit time runs out.
        timer_next = tm_dec;
        if (tm_dec == 24'd0) begin
          phase_next = TX_IDLE;
        end
      end
    endcase
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= TX_IDLE;
      timer <= '0;
      shift <= '0;
      bits  <= '0;
    end else if (step) begin
      phase <= phase_next;
      timer <= timer_next;
      shift <= shift_next;
      bits  <= bits_next;
    end
  end

endmodule

FILE: rtl/uart_8n1_transceiver_core.sv
// Top level of the 8N1 UART transceiver: configuration registers and output staging.
// Depends on u8n1_pkg, u8n1_rx and u8n1_tx.
//
// Usage. Each request on the input channel (in_valid, in_stall) is one time tick
// of the line: the sampled rx_line plus the rx_arm, tx_start/tx_data and
// break_start controls. For each request exactly one result appears on the
// output channel (out_valid, out_stall): tx_line, rx_valid, rx_data,
// rx_timeout, rx_busy and tx_busy for that tick.
// The receiver and transmitter state advance when a request is accepted, and
// its result is registered in the output register at that edge, or in the
// skid register while the output stalls. Throughput is one request per
// cycle while in_stall is low, with both bit timers updated per request.
// When the output stalls, one further result is held in a skid register, so
// a request is still accepted while a result waits; in_stall rises only
// once both the output and skid registers are full.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is bit_period, 1 timeout_ticks, 2 break_ticks, others are ignored.
// Reset clears both state machines and the output stage and loads the
// registers with 416, 65535 and 5000.
module uart_8n1_transceiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        rx_line,
  input  logic        rx_arm,
  input  logic        tx_start,
  input  logic [7:0]  tx_data,
  input  logic        break_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_line,
  output logic        rx_valid,
  output logic [7:0]  rx_data,
  output logic        rx_timeout,
  output logic        rx_busy,
  output logic        tx_busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import u8n1_pkg::*;

  cfg_t       cfg;
  rx_result_t rx_res;
  tx_result_t tx_res;
  result_t    res_new;
  result_t    out_q;
  result_t    skid_q;
  logic       skid_valid;
  logic       accept;
  logic       take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign take      = out_valid && !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_period    <= BIT_PERIOD_RST;
      cfg.timeout_ticks <= TIMEOUT_RST;
      cfg.break_ticks   <= BREAK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_PERIOD: cfg.bit_period    <= cfg_data[15:0];
        REG_TIMEOUT:    cfg.timeout_ticks <= cfg_data[15:0];
        REG_BREAK:      cfg.break_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  u8n1_rx u_rx (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .cfg     (cfg),
    .rx_line (rx_line),
    .rx_arm  (rx_arm),
    .res     (rx_res)
  );

  u8n1_tx u_tx (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .cfg         (cfg),
    .tx_start    (tx_start),
    .tx_data     (tx_data),
    .break_start (break_start),
    .res         (tx_res)
  );

  assign res_new.rx = rx_res;
  assign res_new.tx = tx_res;

  // Output register with a one-entry skid behind it. A request is only
  // accepted while the skid is empty, so the two arms never overlap.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid || take) begin
          out_q     <= res_new;
          out_valid <= 1'b1;
        end else begin
          skid_q     <= res_new;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid) begin
          out_q      <= skid_q;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign tx_line    = out_q.tx.line;
  assign tx_busy    = out_q.tx.busy;
  assign rx_valid   = out_q.rx.valid;
  assign rx_data    = out_q.rx.data;
  assign rx_timeout = out_q.rx.timeout;
  assign rx_busy    = out_q.rx.busy;

endmodule

FILE: tb/sv/uart_8n1_transceiver_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_8n1_transceiver_core: line ticks with frame-shaped stimulus,
// predicted outputs compared in order. Depends on u8n1_pkg and the core RTL only.
module uart_8n1_transceiver_core_test;
  import u8n1_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         TICK_TARGET = 420;

  // Receiver and transmitter phases of the predictor.
  typedef enum logic [2:0] {
    RX_IDLE, RX_WAIT_START, RX_HALF, RX_BITS, RX_WAIT_STOP
  } rx_phase_e;
  typedef enum logic [2:0] {
    TX_IDLE, TX_START_BIT, TX_DATA, TX_STOP_BIT, TX_BREAK
  } tx_phase_e;

  // One tick of the line as carried by an input request.
  typedef struct packed {
    logic       line;
    logic       arm;
    logic       send;
    logic [7:0] data;
    logic       brk;
  } line_tick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        rx_line = 1'b1;
  logic        rx_arm = 1'b0;
  logic        tx_start = 1'b0;
  logic [7:0]  tx_data = 8'h00;
  logic        break_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        tx_line;
  logic        rx_valid;
  logic [7:0]  rx_data;
  logic        rx_timeout;
  logic        rx_busy;
  logic        tx_busy;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [23:0] cfg_data = 24'd0;

  uart_8n1_transceiver_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_line(rx_line), .rx_arm(rx_arm), .tx_start(tx_start), .tx_data(tx_data),
    .break_start(break_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_line(tx_line), .rx_valid(rx_valid), .rx_data(rx_data), .rx_timeout(rx_timeout),
    .rx_busy(rx_busy), .tx_busy(tx_busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Ticks waiting to be sent and outputs waiting to be seen.
  line_tick_t pending_ticks[$];
  result_t    expected_outputs[$];
  int         ticks_made = 0;
  int         errors = 0;

  // Predictor state and its copy of the registers.
  cfg_t        line_cfg;
  rx_phase_e   rx_st;
  logic [15:0] rx_cnt;
  logic [7:0]  rx_byte;
  logic [3:0]  rx_nbits;
  tx_phase_e   tx_st;
  logic [23:0] tx_cnt;
  logic [7:0]  tx_byte;
  logic [3:0]  tx_nbits;

  // Stimulus shaping: effective bit length and wait, and line noise.
  int gen_bit = 416;
  int gen_wait = 65535;
  bit noise_on = 1'b0;

  // Driver and monitor scratch.
  line_tick_t seen_tick;
  line_tick_t next_tick;
  result_t    want;
  int         burst_left = 0;
  int         gap_left = 0;
  logic [7:0] stall_ctr = 8'd0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the transceiver by one tick and return the outputs it gives.
  function automatic result_t advance_uart_model(input line_tick_t t);
    result_t     r;
    logic [15:0] bit_len;
    logic [15:0] wait_len;
    bit_len  = (line_cfg.bit_period < 16'd2) ? 16'd2 : line_cfg.bit_period;
    wait_len = (line_cfg.timeout_ticks == 16'd0) ? 16'd1 : line_cfg.timeout_ticks;
    r = '0;
    r.tx.line = 1'b1;

    // Receiver: arming is seen on the same tick as the first line check.
    if (rx_st == RX_IDLE && t.arm) begin
      rx_st    = RX_WAIT_START;
      rx_cnt   = wait_len;
      rx_byte  = 8'h00;
      rx_nbits = 4'd0;
    end
    if (rx_st != RX_IDLE) begin
      r.rx.busy = 1'b1;
      case (rx_st)
        RX_WAIT_START: begin
          if (!t.line) begin
            rx_st  = RX_HALF;
            rx_cnt = bit_len >> 1;
          end else begin
            rx_cnt = rx_cnt - 16'd1;
            if (rx_cnt == 16'd0) begin
              r.rx.timeout = 1'b1;
              rx_st = RX_IDLE;
            end
          end
        end
        RX_HALF: begin
          rx_cnt = rx_cnt - 16'd1;
          if (rx_cnt == 16'd0) begin
            rx_st  = RX_BITS;
            rx_cnt = bit_len;
          end
        end
        RX_BITS: begin
          rx_cnt = rx_cnt - 16'd1;
          if (rx_cnt == 16'd0) begin
            rx_byte  = rx_byte | (8'(t.line) << rx_nbits);
            rx_nbits = rx_nbits + 4'd1;
            if (rx_nbits >= DATA_BITS) begin
              rx_st  = RX_WAIT_STOP;
              rx_cnt = wait_len;
            end else begin
              rx_cnt = bit_len;
            end
          end
        end
        RX_WAIT_STOP: begin
          if (t.line) begin
            r.rx.valid = 1'b1;
            r.rx.data  = rx_byte;
            rx_st = RX_IDLE;
          end else begin
            rx_cnt = rx_cnt - 16'd1;
            if (rx_cnt == 16'd0) begin
              r.rx.timeout = 1'b1;
              rx_st = RX_IDLE;
            end
          end
        end
        default: rx_st = RX_IDLE;
      endcase
    end

    // Transmitter: a frame takes priority over a break when both are asked for.
    if (tx_st == TX_IDLE) begin
      if (t.send) begin
        tx_st    = TX_START_BIT;
        tx_cnt   = {8'd0, bit_len};
        tx_byte  = t.data;
        tx_nbits = 4'd0;
      end else if (t.brk) begin
        tx_st  = TX_BREAK;
        tx_cnt = (line_cfg.break_ticks == 24'd0) ? 24'd1 : line_cfg.break_ticks;
      end
    end
    if (tx_st != TX_IDLE) begin
      r.tx.busy = 1'b1;
      case (tx_st)
        TX_START_BIT, TX_BREAK: r.tx.line = 1'b0;
        TX_DATA:                r.tx.line = tx_byte[0];
        default:                r.tx.line = 1'b1;
      endcase
      tx_cnt = tx_cnt - 24'd1;
      if (tx_cnt == 24'd0) begin
        case (tx_st)
          TX_START_BIT: begin
            tx_st  = TX_DATA;
            tx_cnt = {8'd0, bit_len};
          end
          TX_DATA: begin
            tx_byte  = tx_byte >> 1;
            tx_nbits = tx_nbits + 4'd1;
            if (tx_nbits >= DATA_BITS) tx_st = TX_STOP_BIT;
            tx_cnt = {8'd0, bit_len};
          end
          default: tx_st = TX_IDLE;
        endcase
      end
    end
    return r;
  endfunction

  task automatic reset_uart_model();
    line_cfg.bit_period    = BIT_PERIOD_RST;
    line_cfg.timeout_ticks = TIMEOUT_RST;
    line_cfg.break_ticks   = BREAK_RST;
    rx_st    = RX_IDLE;
    rx_cnt   = 16'd0;
    rx_byte  = 8'h00;
    rx_nbits = 4'd0;
    tx_st    = TX_IDLE;
    tx_cnt   = 24'd0;
    tx_byte  = 8'h00;
    tx_nbits = 4'd0;
  endtask

  task automatic add_item(input logic line, input logic arm, input logic send,
                          input logic [7:0] data, input logic brk);
    line_tick_t t;
    t.line = line;
    t.arm  = arm;
    t.send = send;
    t.data = data;
    t.brk  = brk;
    pending_ticks.push_back(t);
    ticks_made++;
  endtask

  // A tick with the given line level; transmit requests, breaks and stray arms at random.
  task automatic add_tick(input logic line, input logic arm);
    logic lvl;
    lvl = line;
    if (noise_on && $urandom_range(0, 7) == 0) lvl = ~lvl;
    add_item(lvl, arm | ($urandom_range(0, 39) == 0), $urandom_range(0, 11) == 0,
             8'($urandom), $urandom_range(0, 19) == 0);
  endtask

  // One received frame: armed on its first tick, lead ticks of idle line, then
  // start bit, eight data bits and a stop level that is either high or held low.
  task automatic add_rx_frame(input logic [7:0] val, input int lead, input bit stop_good);
    int k;
    for (k = 0; k < lead; k++) add_tick(1'b1, k == 0);
    for (k = 0; k < gen_bit; k++) add_tick(1'b0, lead == 0 && k == 0);
    for (k = 0; k < 8 * gen_bit; k++) add_tick(val[k / gen_bit], 1'b0);
    if (stop_good) begin
      for (k = 0; k < gen_bit + $urandom_range(0, 2); k++) add_tick(1'b1, 1'b0);
    end else begin
      for (k = 0; k < $urandom_range(1, gen_wait + 2); k++) add_tick(1'b0, 1'b0);
    end
  endtask

  // Wait until every tick is sent and every output has been seen.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_outputs.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_BIT_PERIOD: line_cfg.bit_period    = val[15:0];
      REG_TIMEOUT:    line_cfg.timeout_ticks = val[15:0];
      REG_BREAK:      line_cfg.break_ticks   = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input int bit_val, input int tmo_val, input int brk_val);
    wait_idle();
    write_reg(REG_BIT_PERIOD, 24'(bit_val));
    write_reg(REG_TIMEOUT, 24'(tmo_val));
    write_reg(REG_BREAK, 24'(brk_val));
    gen_bit  = (bit_val < 2) ? 2 : bit_val;
    gen_wait = (tmo_val == 0) ? 1 : tmo_val;
  endtask

  // Driver: sends ticks in bursts and predicts each accepted request.
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        seen_tick.line = rx_line;
        seen_tick.arm  = rx_arm;
        seen_tick.send = tx_start;
        seen_tick.data = tx_data;
        seen_tick.brk  = break_start;
        expected_outputs.push_back(advance_uart_model(seen_tick));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_ticks.size() != 0) begin
          next_tick = pending_ticks.pop_front();
          in_valid    <= 1'b1;
          rx_line     <= next_tick.line;
          rx_arm      <= next_tick.arm;
          tx_start    <= next_tick.send;
          tx_data     <= next_tick.data;
          break_start <= next_tick.brk;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: stalls on a rotating pattern and checks each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_ctr <= 8'd0;
    end else begin
      stall_ctr <= stall_ctr + 8'd1;
      case (stall_ctr[7:6])
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 2) == 0);
        2'd2:    out_stall <= (stall_ctr[2:0] > 3'd4);
        default: out_stall <= ($urandom_range(0, 7) < 5);
      endcase
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tx_line %0b rx_valid %0b",
                   $time, tx_line, rx_valid);
          errors++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("tx_line", 8'(want.tx.line), 8'(tx_line));
          check_field("tx_busy", 8'(want.tx.busy), 8'(tx_busy));
          check_field("rx_valid", 8'(want.rx.valid), 8'(rx_valid));
          check_field("rx_data", want.rx.data, rx_data);
          check_field("rx_timeout", 8'(want.rx.timeout), 8'(rx_timeout));
          check_field("rx_busy", 8'(want.rx.busy), 8'(rx_busy));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int r;
    int kind;
    int lead;
    int k;
    reset_uart_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Arm under the reset registers; the receiver is still waiting when they change.
    add_item(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);

    // Directed: every register below its floor, so bit length 2 and waits of one tick.
    set_regs(1, 0, 0);
    add_item(1'b0, 1'b0, 1'b1, 8'hFF, 1'b1);    // start edge; frame wins over break
    for (k = 0; k < 18; k++) add_item(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_item(1'b1, 1'b1, 1'b0, 8'h00, 1'b1);    // arm times out at once; break on last tick
    add_item(1'b1, 1'b0, 1'b0, 8'h00, 1'b1);    // break taken one tick later
    add_item(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);    // arm with edge on the same tick
    for (k = 0; k < 22; k++) add_item(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);

    // Random frames under short register settings, some broken or noisy.
    while (ticks_made < TICK_TARGET) begin
      r = $urandom_range(0, 9);
      set_regs((r == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6),
               (r == 1) ? 0 : $urandom_range(1, 30),
               (r == 2) ? 0 : $urandom_range(1, 25));
      repeat ($urandom_range(3, 6)) begin
        kind = $urandom_range(0, 9);
        noise_on = (kind == 9);
        if (kind == 7) lead = gen_wait + $urandom_range(0, 2);
        else lead = $urandom_range(0, (gen_wait > 8) ? 7 : gen_wait - 1);
        add_rx_frame(8'($urandom), lead, kind != 8);
        noise_on = 1'b0;
        repeat ($urandom_range(0, 3)) add_tick(1'b1, 1'b0);
      end
    end

    // Quiet line so both sides are idle before the largest settings.
    for (k = 0; k < 100; k++) add_item(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    wait_idle();
    write_reg(REG_BIT_PERIOD, 24'hFFFFFF);
    write_reg(REG_TIMEOUT, 24'h00FFFF);
    write_reg(REG_BREAK, 24'hFFFFFF);
    write_reg(REG_UNUSED, 24'h5A5A5A);
    add_item(1'b1, 1'b1, 1'b0, 8'h00, 1'b1);    // long break and a long start wait
    for (k = 0; k < 10; k++) add_item(1'b1, 1'b0, k == 4, 8'hFF, 1'b0);
    for (k = 0; k < 20; k++) add_item(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);

    wait_idle();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("uart_8n1_transceiver_core test passed");
    end else begin
      $display("uart_8n1_transceiver_core test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("uart_8n1_transceiver_core test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/u8n1_pkg.sv
rtl/u8n1_rx.sv
rtl/u8n1_tx.sv
rtl/uart_8n1_transceiver_core.sv
tb/sv/uart_8n1_transceiver_core_test.sv
